// ----- rtl/core/ppos_pkg.sv -----
// Shared widths, constants and arctangent table of the polar origin shift core.
package ppos_pkg;

	localparam int ANGLE_SHIFT_DEF   = 1;
	localparam int CORDIC_STAGES_DEF = 18;
	localparam int TABLE_LEN         = 24;

	localparam int VEC_W   = 37;
	localparam int ANG_W   = 27;
	localparam int PNT_W   = 19;
	localparam int OFF_W   = 18;
	localparam int FRAC    = 14;
	localparam int ANG_FRAC = 10;
	localparam int INVK_W  = 30;
	localparam int DIST_W  = 19;
	localparam int NANG_W  = 15;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [PNT_W-1:0] pnt_t;
	typedef logic signed [OFF_W-1:0] off_t;

	localparam logic [INVK_W-1:0] INVK = 30'd652032874;

	localparam logic [15:0]        FULL_TURN_U = 16'd23040;
	localparam logic signed [15:0] FULL_TURN   = 16'sd23040;
	localparam logic signed [15:0] HALF_TURN   = 16'sd11520;
	localparam logic signed [15:0] QUARTER_POS = 16'sd5760;
	localparam logic signed [15:0] QUARTER_NEG = -16'sd5760;

	localparam vec_t ROUND_HALF = vec_t'(1) <<< (FRAC - 1);
	localparam ang_t ANG_HALF   = ang_t'(1) <<< (ANG_FRAC - 1);
	localparam ang_t Z_HALF     = 27'sd11796480;
	localparam ang_t ANG_POS    = 27'sd11520;
	localparam ang_t ANG_NEG    = -27'sd11520;

	localparam logic [DIST_W-1:0] DIST_MAX = 19'd278046;

	localparam logic REG_OFFSET_X = 1'b0;
	localparam logic REG_OFFSET_Y = 1'b1;

	function automatic ang_t atan_entry(input int idx);
		case (idx)
			0: return 27'sd2949120;
			1: return 27'sd1740967;
			2: return 27'sd919879;
			3: return 27'sd466945;
			4: return 27'sd234379;
			5: return 27'sd117304;
			6: return 27'sd58666;
			7: return 27'sd29335;
			8: return 27'sd14668;
			9: return 27'sd7334;
			10: return 27'sd3667;
			11: return 27'sd1833;
			12: return 27'sd917;
			13: return 27'sd458;
			14: return 27'sd229;
			15: return 27'sd115;
			16: return 27'sd57;
			17: return 27'sd29;
			18: return 27'sd14;
			19: return 27'sd7;
			20: return 27'sd4;
			21: return 27'sd2;
			22: return 27'sd1;
			default: return '0;
		endcase
	endfunction

endpackage

// ----- rtl/core/ppos_cell.sv -----
// One CORDIC micro-rotation cell, rotation or vectoring mode, with registered outputs.
module ppos_cell #(
	parameter int STAGE     = 0,
	parameter bit VECTORING = 1'b0
) (
	input  logic          clk,
	input  ppos_pkg::vec_t x_in,
	input  ppos_pkg::vec_t y_in,
	input  ppos_pkg::ang_t z_in,
	output ppos_pkg::vec_t x_q,
	output ppos_pkg::vec_t y_q,
	output ppos_pkg::ang_t z_q
);
	import ppos_pkg::*;

	localparam ang_t STEP_ANGLE = atan_entry(STAGE);

	vec_t x_sh;
	vec_t y_sh;
	logic dir_pos;

	assign x_sh    = x_in >>> STAGE;
	assign y_sh    = y_in >>> STAGE;
	assign dir_pos = VECTORING ? y_in[VEC_W-1] : !z_in[ANG_W-1];

	always_ff @(posedge clk) begin
		if (dir_pos) begin
			x_q <= x_in - y_sh;
			y_q <= y_in + x_sh;
			z_q <= z_in - STEP_ANGLE;
		end else begin
			x_q <= x_in + y_sh;
			y_q <= y_in - x_sh;
			z_q <= z_in + STEP_ANGLE;
		end
	end

endmodule

// ----- rtl/core/polar_point_origin_shift_core.sv -----
// Top level: polar to Cartesian, origin offset, and back to polar, as two rows of CORDIC cells.
// Throughput: one transaction per cycle; busy is never high.
// The pipeline is built from the forward and inverse rows of CORDIC cells, each cell one register stage.
// Reset clears the offset registers and the valid pipeline; transactions in flight are dropped.
// Results appear for one cycle with done; the receiver cannot stall them.
module polar_point_origin_shift_core #(
	parameter int ANGLE_SHIFT   = ppos_pkg::ANGLE_SHIFT_DEF,
	parameter int CORDIC_STAGES = ppos_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        raw_angle,
	input  logic [15:0]        raw_distance,
	output logic               done,
	output logic signed [18:0] shifted_x,
	output logic signed [18:0] shifted_y,
	output logic signed [14:0] new_angle,
	output logic [18:0]        new_distance
);
	import ppos_pkg::*;

	localparam int STAGES  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
	localparam int LAT     = 2 * STAGES + 6;
	localparam int PROD_W  = 16 + INVK_W;
	localparam int MAG_W   = VEC_W - 1;
	localparam int SPLIT   = 17;
	localparam int HI_W    = MAG_W - SPLIT;
	localparam int PLO_W   = SPLIT + INVK_W;
	localparam int PHI_W   = HI_W + INVK_W;
	localparam int SUM_W   = PHI_W + SPLIT + 2;
	localparam int DSHIFT  = 44;
	localparam int T_W     = SUM_W - DSHIFT;

	// configuration port
	off_t offset_x_q;
	off_t offset_y_q;
	off_t rd_sel;
	logic reg_idx;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_OFFSET_X: offset_x_q <= off_t'(pwdata[OFF_W-1:0]);
				REG_OFFSET_Y: offset_y_q <= off_t'(pwdata[OFF_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_OFFSET_X: rd_sel = offset_x_q;
			REG_OFFSET_Y: rd_sel = offset_y_q;
			default:      rd_sel = '0;
		endcase
	end

	assign prdata = 32'(rd_sel);

	// valid pipeline
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	assign done = vld_q[LAT-1];

	// front end: angle wrap and fold, gain-corrected radius
	logic [15:0]        ang_sh;
	logic [15:0]        ang_m1;
	logic [15:0]        ang_m2;
	logic signed [15:0] ang_f;
	logic               neg_f;
	logic [PROD_W-1:0]  prod;

	assign ang_sh = raw_angle >> ANGLE_SHIFT;
	assign ang_m1 = (ang_sh >= FULL_TURN_U) ? ang_sh - FULL_TURN_U : ang_sh;
	assign ang_m2 = (ang_m1 >= FULL_TURN_U) ? ang_m1 - FULL_TURN_U : ang_m1;
	assign prod   = {{INVK_W{1'b0}}, raw_distance} * {16'b0, INVK};

	always_comb begin
		ang_f = signed'(ang_m2);
		neg_f = 1'b0;
		if (ang_f > HALF_TURN) begin
			ang_f = ang_f - FULL_TURN;
		end
		if (ang_f > QUARTER_POS) begin
			ang_f = ang_f - HALF_TURN;
			neg_f = 1'b1;
		end else if (ang_f < QUARTER_NEG) begin
			ang_f = ang_f + HALF_TURN;
			neg_f = 1'b1;
		end
	end

	logic signed [15:0] ang_s1;
	logic               neg_s1;
	logic [PROD_W-1:0]  prod_s1;

	always_ff @(posedge clk) begin
		ang_s1  <= ang_f;
		neg_s1  <= neg_f;
		prod_s1 <= prod;
	end

	vec_t x0_mag;
	vec_t x_s2;
	vec_t y_s2;
	ang_t z_s2;

	assign x0_mag = vec_t'(signed'({1'b0, prod_s1[PROD_W-1:16]}));

	always_ff @(posedge clk) begin
		x_s2 <= neg_s1 ? -x0_mag : x0_mag;
		y_s2 <= '0;
		z_s2 <= ang_t'(ang_s1) <<< ANG_FRAC;
	end

	// forward row: rotation mode
	vec_t fx [0:STAGES];
	vec_t fy [0:STAGES];
	ang_t fz [0:STAGES];

	assign fx[0] = x_s2;
	assign fy[0] = y_s2;
	assign fz[0] = z_s2;

	for (genvar k = 0; k < STAGES; k++) begin : g_fwd
		ppos_cell #(.STAGE(k), .VECTORING(1'b0)) u_cell (
			.clk  (clk),
			.x_in (fx[k]),
			.y_in (fy[k]),
			.z_in (fz[k]),
			.x_q  (fx[k+1]),
			.y_q  (fy[k+1]),
			.z_q  (fz[k+1])
		);
	end

	// round to quarter millimetres and add the origin offset
	vec_t rx;
	vec_t ry;
	pnt_t sx_s3;
	pnt_t sy_s3;

	assign rx = (fx[STAGES] + ROUND_HALF) >>> FRAC;
	assign ry = (fy[STAGES] + ROUND_HALF) >>> FRAC;

	always_ff @(posedge clk) begin
		sx_s3 <= pnt_t'(rx) + pnt_t'(offset_x_q);
		sy_s3 <= pnt_t'(ry) + pnt_t'(offset_y_q);
	end

	// inverse row setup: move into the right half plane
	vec_t xi;
	vec_t yi;
	vec_t x_s4;
	vec_t y_s4;
	ang_t z_s4;
	pnt_t sx_s4;
	pnt_t sy_s4;
	logic zero_s4;

	assign xi = vec_t'(sx_s3) <<< FRAC;
	assign yi = vec_t'(sy_s3) <<< FRAC;

	always_ff @(posedge clk) begin
		if (sx_s3[PNT_W-1]) begin
			x_s4 <= -xi;
			y_s4 <= -yi;
			z_s4 <= sy_s3[PNT_W-1] ? -Z_HALF : Z_HALF;
		end else begin
			x_s4 <= xi;
			y_s4 <= yi;
			z_s4 <= '0;
		end
		sx_s4   <= sx_s3;
		sy_s4   <= sy_s3;
		zero_s4 <= (sx_s3 == '0) && (sy_s3 == '0);
	end

	// inverse row: vectoring mode, with the point carried alongside
	vec_t ix [0:STAGES];
	vec_t iy [0:STAGES];
	ang_t iz [0:STAGES];
	pnt_t sx_chain_q [0:STAGES-1];
	pnt_t sy_chain_q [0:STAGES-1];
	logic zero_chain_q [0:STAGES-1];

	assign ix[0] = x_s4;
	assign iy[0] = y_s4;
	assign iz[0] = z_s4;

	for (genvar k = 0; k < STAGES; k++) begin : g_inv
		ppos_cell #(.STAGE(k), .VECTORING(1'b1)) u_cell (
			.clk  (clk),
			.x_in (ix[k]),
			.y_in (iy[k]),
			.z_in (iz[k]),
			.x_q  (ix[k+1]),
			.y_q  (iy[k+1]),
			.z_q  (iz[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sx_chain_q[0]   <= sx_s4;
		sy_chain_q[0]   <= sy_s4;
		zero_chain_q[0] <= zero_s4;
		for (int k = 1; k < STAGES; k++) begin
			sx_chain_q[k]   <= sx_chain_q[k-1];
			sy_chain_q[k]   <= sy_chain_q[k-1];
			zero_chain_q[k] <= zero_chain_q[k-1];
		end
	end

	// angle rounding and saturation, split distance scaling
	ang_t             ang_round;
	ang_t             ang_sat;
	logic [MAG_W-1:0] x_mag;
	logic signed [NANG_W-1:0] ang_s5;
	logic [PLO_W-1:0] plo_s5;
	logic [PHI_W-1:0] phi_s5;
	pnt_t             sx_s5;
	pnt_t             sy_s5;
	logic             zero_s5;

	assign ang_round = (iz[STAGES] + ANG_HALF) >>> ANG_FRAC;
	assign x_mag     = ix[STAGES][VEC_W-1] ? '0 : ix[STAGES][MAG_W-1:0];

	always_comb begin
		ang_sat = ang_round;
		if (ang_round > ANG_POS) begin
			ang_sat = ANG_POS;
		end else if (ang_round < ANG_NEG) begin
			ang_sat = ANG_NEG;
		end
	end

	always_ff @(posedge clk) begin
		ang_s5  <= zero_chain_q[STAGES-1] ? '0 : ang_sat[NANG_W-1:0];
		plo_s5  <= {{INVK_W{1'b0}}, x_mag[SPLIT-1:0]} * {{SPLIT{1'b0}}, INVK};
		phi_s5  <= {{INVK_W{1'b0}}, x_mag[MAG_W-1:SPLIT]} * {{HI_W{1'b0}}, INVK};
		sx_s5   <= sx_chain_q[STAGES-1];
		sy_s5   <= sy_chain_q[STAGES-1];
		zero_s5 <= zero_chain_q[STAGES-1];
	end

	// output stage
	logic [SUM_W-1:0] dsum;
	logic [T_W-1:0]   dist_t;

	assign dsum   = (SUM_W'(phi_s5) << SPLIT) + SUM_W'(plo_s5)
		+ (SUM_W'(1) << (DSHIFT - 1));
	assign dist_t = dsum[SUM_W-1:DSHIFT];

	always_ff @(posedge clk) begin
		shifted_x <= sx_s5;
		shifted_y <= sy_s5;
		new_angle <= ang_s5;
		if (zero_s5) begin
			new_distance <= '0;
		end else if (dist_t > T_W'(DIST_MAX)) begin
			new_distance <= DIST_MAX;
		end else begin
			new_distance <= dist_t[DIST_W-1:0];
		end
	end

endmodule
